// ----- src/at_keyboard_controller_with_typematic_macros.svh -----
// Assertion macros shared by the keyboard controller modules.
// Included by the files that carry concurrent assertions.
`ifndef AT_KEYBOARD_CONTROLLER_WITH_TYPEMATIC_MACROS_SVH
`define AT_KEYBOARD_CONTROLLER_WITH_TYPEMATIC_MACROS_SVH
`ifndef SYNTHESIS
`define AKC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AKC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKC_ASSERT(label, clk, rst_n, prop, msg)
`define AKC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- src/akc_pkg.sv -----
// Shared types, constants and lookup functions of the keyboard controller.
// No dependencies.
package akc_pkg;

  localparam int RingDepth = 256;
  localparam int RingAw    = $clog2(RingDepth);
  localparam int KeyCount  = 112;
  localparam int KeyAw     = $clog2(KeyCount);
  localparam int SeqMax    = 8;
  localparam int SeqAw     = $clog2(SeqMax + 1);

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_DELAY  = 2'd0;
  localparam logic [1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_MF2    = 2'd2;
  localparam logic [1:0] CFG_INPORT = 2'd3;

  localparam logic [2:0] OFFS_DATA   = 3'd0;
  localparam logic [2:0] OFFS_STATUS = 3'd4;

  localparam logic [7:0] KEY_NUMLOCK = 8'h45;

  typedef enum logic [1:0] {
    CST_IDLE = 2'd0,
    CST_EXEC = 2'd1,
    CST_PUSH = 2'd2
  } ctl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic commit;
    logic push;
    logic finish;
  } akc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seq_left;
  } akc_sts_t;

  function automatic logic [7:0] ext_base(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h12;  4'd1: r = 8'h13;  4'd2: r = 8'h35;  4'd3: r = 8'h37;
      4'd4: r = 8'h38;  4'd5: r = 8'h47;  4'd6: r = 8'h48;  4'd7: r = 8'h49;
      4'd8: r = 8'h4B;  4'd9: r = 8'h4D;  4'd10: r = 8'h4F; 4'd11: r = 8'h50;
      4'd12: r = 8'h51; 4'd13: r = 8'h52; 4'd14: r = 8'h53;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pause_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'hE1; 3'd1: r = 8'h1D; 3'd2: r = 8'h45;
      3'd3: r = 8'hE1; 3'd4: r = 8'h9D; 3'd5: r = 8'hC5;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- src/akc_ctrl.sv -----
// Sequencer of the keyboard controller: accepts a request, runs it, then
// drains queued scancode bytes one per cycle. Uses akc_pkg.
`include "at_keyboard_controller_with_typematic_macros.svh"
module akc_ctrl import akc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  akc_sts_t sts,
  output akc_cmd_t cmd,
  output logic     busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    case (state_r)
      CST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = CST_EXEC;
        end
      end
      CST_EXEC: begin
        cmd.commit = 1'b1;
        state_nxt  = CST_PUSH;
      end
      CST_PUSH: begin
        if (sts.seq_left) begin
          cmd.push = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = CST_IDLE;
        end
      end
      default: state_nxt = CST_IDLE;
    endcase
  end

  `AKC_ASSERT(a_no_start_busy, clk, rst_n, (busy |-> !cmd.exec), "exec while busy")
  `AKC_ASSERT(a_one_cmd, clk, rst_n, $onehot0({cmd.exec, cmd.commit, cmd.push, cmd.finish}), "cmd clash")
  `AKC_ASSERT(a_finish_idle, clk, rst_n, (cmd.finish |=> !busy), "finish not idle")
  `AKC_ASSERT(a_exec_busy, clk, rst_n, (cmd.exec |=> cmd.commit), "exec not followed by commit")

endmodule

// ----- src/akc_dp.sv -----
// Datapath of the keyboard controller: hold counters, scancode ring, host
// registers and the result register. Uses akc_pkg, driven by akc_ctrl.
`include "at_keyboard_controller_with_typematic_macros.svh"
module akc_dp import akc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  akc_cmd_t   cmd,
  output akc_sts_t   sts,
  input  logic [1:0] in_command,
  input  logic [6:0] in_key_code,
  input  logic       in_key_pressed,
  input  logic [2:0] in_port_offset,
  input  logic [7:0] in_write_data,
  input  logic       in_irq_pending,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_irq_request,
  output logic       out_address_mask_update,
  output logic       out_address_wide,
  output logic       out_cpu_reset_pulse
);

  logic [7:0] delay_r, period_r, inport_r;
  logic       mf2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= 8'd60;
      period_r <= 8'd8;
      mf2_r    <= 1'b0;
      inport_r <= 8'h80;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DELAY:  delay_r  <= cfg_data;
        CFG_PERIOD: period_r <= cfg_data;
        CFG_MF2:    mf2_r    <= cfg_data[0];
        CFG_INPORT: inport_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request captured at accept.
  logic [1:0] cmd_r;
  logic [6:0] key_r;
  logic       prs_r, irqp_r;
  logic [2:0] offs_r;
  logic [7:0] wd_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cmd_r  <= in_command;
      key_r  <= in_key_code;
      prs_r  <= in_key_pressed;
      offs_r <= in_port_offset;
      wd_r   <= in_write_data;
      irqp_r <= in_irq_pending;
    end
  end

  // Hold counters: valid bits give the all-zero reset, the counts live in a memory.
  logic [7:0]          hold_mem [KeyCount];
  logic [KeyCount-1:0] hold_vld_r;
  logic [7:0]          hold_rd_r;
  logic                hold_we;
  logic [7:0]          hold_wv;

  always_ff @(posedge clk) begin
    if (cmd.exec) hold_rd_r <= hold_mem[in_key_code[KeyAw-1:0]];
    if (cmd.commit && hold_we) hold_mem[key_r[KeyAw-1:0]] <= hold_wv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hold_vld_r <= '0;
    else if (cmd.commit && hold_we) hold_vld_r[key_r[KeyAw-1:0]] <= 1'b1;
  end

  // Scancode ring; the byte at the tail is read when a request is accepted.
  logic [7:0]       ring_mem [RingDepth];
  logic [RingAw-1:0] head_r, tail_r;
  logic [RingAw:0]   fill_r;
  logic              push_en;
  logic [7:0]        push_b;
  logic [7:0]        pop_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) pop_rd_r <= ring_mem[tail_r];
  end

  always_ff @(posedge clk) begin
    if (push_en && fill_r != (RingAw+1)'(RingDepth)) ring_mem[head_r] <= push_b;
  end

  // Pending push sequence (up to eight bytes).
  logic [SeqMax-1:0][7:0] seq_r, seq_nxt;
  logic [SeqAw-1:0]       seqn_r, seqn_nxt;

  logic       numlock_r, numlock_nxt;
  logic [1:0] kph_r, kph_nxt;
  logic [7:0] data_r, data_nxt, oport_r, oport_nxt;
  logic       full_r, full_nxt, send_r, send_nxt, kif_r, kif_nxt;
  logic [1:0] smode_r, smode_nxt;
  logic [2:0] wph_r, wph_nxt;
  logic       pop_en;
  logic [7:0] rd, s;
  logic       irq, upd, rst;
  logic [7:0] hc, c, key8;
  logic [8:0] dsum;
  logic       emit, rel;
  logic [3:0] xi;
  logic       shifted;

  assign sts.seq_left = seqn_r != '0;

  always_comb begin
    seq_nxt = '0; seqn_nxt = '0;
    numlock_nxt = numlock_r; kph_nxt = kph_r; data_nxt = data_r; oport_nxt = oport_r;
    full_nxt = full_r; send_nxt = send_r; kif_nxt = kif_r; smode_nxt = smode_r;
    wph_nxt = wph_r; pop_en = 1'b0; rd = '0; irq = 1'b0; upd = 1'b0; rst = 1'b0;
    hold_we = 1'b0; hold_wv = '0; emit = 1'b0; rel = 1'b0; s = 8'h04;
    key8 = {1'b0, key_r};
    hc = hold_vld_r[key_r[KeyAw-1:0]] ? hold_rd_r : 8'd0;
    c = hc + 8'd1;
    dsum = {1'b0, delay_r} + {1'b0, period_r};
    xi = key_r[3:0];
    shifted = 1'b0;
    case (cmd_r)
      CMD_SCAN: begin
        if (key_r != '0 && key8 < 8'(KeyCount)) begin
          if (prs_r) begin
            hold_we = 1'b1;
            if (hc == 8'd0) begin
              hold_wv = 8'd1; emit = 1'b1;
              if (key8 == KEY_NUMLOCK) numlock_nxt = ~numlock_r;
            end else begin
              hold_wv = c;
              if (c == delay_r) emit = 1'b1;
              else if ({1'b0, c} == dsum) begin
                hold_wv = delay_r; emit = 1'b1;
              end
            end
          end else if (hc != 8'd0) begin
            hold_we = 1'b1; hold_wv = 8'd0; emit = 1'b1; rel = 1'b1;
          end
        end
        // numlock for the sequence uses the value after toggling
        if (emit) begin
          if (key_r < 7'h60) begin
            seq_nxt[0] = rel ? {1'b1, key_r} : key8; seqn_nxt = SeqAw'(1);
          end else if (xi == 4'hF) begin
            if (!rel) begin
              if (numlock_nxt) begin
                seq_nxt[0] = 8'hE0; seq_nxt[1] = 8'h2A;
                for (int i = 0; i < 6; i++) seq_nxt[i+2] = pause_byte(3'(i));
                seqn_nxt = SeqAw'(8);
              end else begin
                for (int i = 0; i < 6; i++) seq_nxt[i] = pause_byte(3'(i));
                seqn_nxt = SeqAw'(6);
              end
            end
          end else begin
            shifted = numlock_nxt && xi >= 4'd5;
            if (!rel) begin
              if (shifted) begin
                seq_nxt[0] = 8'hE0; seq_nxt[1] = 8'h2A;
                seq_nxt[2] = 8'hE0; seq_nxt[3] = ext_base(xi); seqn_nxt = SeqAw'(4);
              end else begin
                seq_nxt[0] = 8'hE0; seq_nxt[1] = ext_base(xi); seqn_nxt = SeqAw'(2);
              end
            end else begin
              seq_nxt[0] = 8'hE0; seq_nxt[1] = ext_base(xi) | 8'h80;
              seq_nxt[2] = 8'hE0; seq_nxt[3] = 8'hAA;
              seqn_nxt = shifted ? SeqAw'(4) : SeqAw'(2);
            end
          end
        end
      end
      CMD_FRAME: begin
        if (!irqp_r && !full_r && fill_r != '0) begin
          pop_en = 1'b1; data_nxt = pop_rd_r; full_nxt = 1'b1; irq = 1'b1;
        end
      end
      CMD_READ: begin
        if (offs_r == OFFS_DATA) begin
          rd = data_r; full_nxt = 1'b0;
        end else if (offs_r == OFFS_STATUS) begin
          if (!full_r && fill_r != '0) begin
            pop_en = 1'b1; data_nxt = pop_rd_r; full_nxt = 1'b1; irq = !irqp_r;
          end
          if (full_nxt) s[0] = 1'b1;
          if (send_r) s[1] = 1'b1;
          send_nxt = 1'b0;
          case (smode_r)
            2'd0: if (!kif_r) s[4] = 1'b1;
            2'd1: s = s | {4'h0, inport_r[3:0]};
            2'd2: s = s | {inport_r[3:0], 4'h0};
            default: ;
          endcase
          rd = s;
        end
      end
      default: begin
        if (offs_r == OFFS_DATA) begin
          smode_nxt = 2'd0;
          if (wph_r == 3'd0 || wph_r == 3'd2) begin
            wph_nxt = 3'd0; data_nxt = wd_r; send_nxt = 1'b1;
            if (kph_r != 2'd0) kph_nxt = 2'd0;
            else begin
              case (wd_r)
                8'hED: kph_nxt = 2'd1;
                8'hEE: begin seq_nxt[0] = 8'hEE; seqn_nxt = SeqAw'(1); end
                8'hF0: kph_nxt = 2'd2;
                8'hF2: begin
                  seq_nxt[0] = 8'hFA; seq_nxt[1] = 8'hAB; seq_nxt[2] = 8'h41;
                  seqn_nxt = mf2_r ? SeqAw'(3) : SeqAw'(1);
                end
                8'hF3: kph_nxt = 2'd3;
                8'hFF: begin seq_nxt[0] = 8'hFA; seq_nxt[1] = 8'hAA; seqn_nxt = SeqAw'(2); end
                default: ;
              endcase
            end
          end else if (wph_r == 3'd1) begin
            wph_nxt = 3'd0; oport_nxt = wd_r; upd = 1'b1;
          end else if (wph_r == 3'd3 || wph_r == 3'd4) begin
            wph_nxt = 3'd0; data_nxt = wd_r;
          end
        end else if (offs_r == OFFS_STATUS) begin
          case (wd_r)
            8'hA9, 8'hAB: begin data_nxt = 8'h00; full_nxt = 1'b1; irq = !irqp_r; end
            8'hAA: begin data_nxt = 8'h55; full_nxt = 1'b1; irq = !irqp_r; end
            8'hAD: kif_nxt = 1'b0;
            8'hAE: kif_nxt = 1'b1;
            8'hC0: begin data_nxt = inport_r; full_nxt = 1'b1; irq = !irqp_r; end
            8'hC1: smode_nxt = 2'd1;
            8'hC2: smode_nxt = 2'd2;
            8'hD0: begin data_nxt = oport_r; full_nxt = 1'b1; irq = !irqp_r; end
            8'hD1: wph_nxt = 3'd1;
            8'hD2: wph_nxt = 3'd2;
            8'hD3: wph_nxt = 3'd3;
            8'hD4: wph_nxt = 3'd4;
            default: if (wd_r[7:4] == 4'hF && !wd_r[0]) rst = 1'b1;
          endcase
          send_nxt = 1'b1;
        end
      end
    endcase
  end

  assign push_en = cmd.push;
  assign push_b  = seq_r[0];

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numlock_r <= 1'b0; kph_r <= '0; data_r <= '0; oport_r <= '0; full_r <= 1'b0;
      send_r <= 1'b0; kif_r <= 1'b0; smode_r <= '0; wph_r <= '0; seqn_r <= '0;
      head_r <= '0; tail_r <= '0; fill_r <= '0; out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.push) begin
        seq_r  <= {8'h00, seq_r[SeqMax-1:1]};
        seqn_r <= seqn_r - SeqAw'(1);
        if (fill_r != (RingAw+1)'(RingDepth)) begin
          head_r <= head_r + RingAw'(1);
          fill_r <= fill_r + (RingAw+1)'(1);
        end
      end
      // The request's effects are committed in the cycle after accept.
      if (cmd.commit) begin
        numlock_r <= numlock_nxt; kph_r <= kph_nxt; data_r <= data_nxt;
        oport_r <= oport_nxt; full_r <= full_nxt; send_r <= send_nxt; kif_r <= kif_nxt;
        smode_r <= smode_nxt; wph_r <= wph_nxt; seq_r <= seq_nxt; seqn_r <= seqn_nxt;
        if (pop_en) begin
          tail_r <= tail_r + RingAw'(1);
          fill_r <= fill_r - (RingAw+1)'(1);
        end
      end
    end
  end

  // Results are held from the commit cycle until finish.
  logic [7:0] rd_r;
  logic irq_r, upd_r, rst_o_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_r <= rd; irq_r <= irq; upd_r <= upd; rst_o_r <= rst;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = out_valid_r ? rd_r : 8'd0;
  assign out_irq_request         = out_valid_r & irq_r;
  assign out_address_mask_update = out_valid_r & upd_r;
  assign out_address_wide        = oport_r[1];
  assign out_cpu_reset_pulse     = out_valid_r & rst_o_r;

  `AKC_ASSERT(a_fill_max, clk, rst_n, (fill_r <= (RingAw+1)'(RingDepth)), "fill overflow")
  `AKC_ASSERT(a_ring_ptr, clk, rst_n, (fill_r == '0 |-> head_r == tail_r), "empty ring with split pointers")
  `AKC_ASSERT(a_push_seq, clk, rst_n, (cmd.push |-> seqn_r != '0), "push with empty sequence")

endmodule

// ----- src/at_keyboard_controller_with_typematic.sv -----
// Top level of the AT keyboard controller with typematic keyboard.
// Instantiates akc_ctrl and akc_dp; uses akc_pkg.
//
// Channel   Direction  Handshake
// in_*      input      start high and busy low
// out_*     output     out_valid strobe, one cycle, no backpressure
// cfg_*     input      cfg_valid and cfg_ready
//
// A request is committed after accept, then its queued scancode bytes (up to 8)
// are written one at a time through the ring memory's single write port; no new
// request is accepted until the last of them is queued.
// Reset is synchronous and active low; the ring needs no clearing pass.
// The result strobe comes in the same cycle as busy falls, and the receiver
// cannot stall it.
`include "at_keyboard_controller_with_typematic_macros.svh"
module at_keyboard_controller_with_typematic import akc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [6:0] in_key_code,
  input  logic       in_key_pressed,
  input  logic [2:0] in_port_offset,
  input  logic [7:0] in_write_data,
  input  logic       in_irq_pending,
  output logic       out_valid,
  output logic [7:0] out_read_data,
  output logic       out_irq_request,
  output logic       out_address_mask_update,
  output logic       out_address_wide,
  output logic       out_cpu_reset_pulse,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  akc_cmd_t cmd;
  akc_sts_t sts;

  assign cfg_ready = 1'b1;

  akc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  akc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_command(in_command), .in_key_code(in_key_code),
    .in_key_pressed(in_key_pressed), .in_port_offset(in_port_offset),
    .in_write_data(in_write_data), .in_irq_pending(in_irq_pending),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_read_data(out_read_data),
    .out_irq_request(out_irq_request),
    .out_address_mask_update(out_address_mask_update),
    .out_address_wide(out_address_wide), .out_cpu_reset_pulse(out_cpu_reset_pulse)
  );

  `AKC_ASSERT(a_out_after_busy, clk, rst_n, (out_valid |-> $past(busy)), "result without request")
  `AKC_ASSERT(a_start_when_idle, clk, rst_n, ((start && !busy) |=> busy), "accept did not set busy")
  `AKC_ASSERT(a_no_out_idle, clk, rst_n, ((!busy && $past(!busy)) |-> !out_valid), "stray result")

endmodule
